>>> rtl/oaat_pkg.sv
`timescale 1ns / 1ps

package oaat_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned HASH_W = 32;

  localparam logic [BYTE_W-1:0] UPPER_FIRST = 8'h41;
  localparam logic [BYTE_W-1:0] UPPER_LAST  = 8'h5A;
  localparam logic [BYTE_W-1:0] CASE_OFFSET = 8'h20;

  // Finished running value handed from the mixing stage to the finalizer.
  typedef struct packed {
    logic              valid;
    logic [HASH_W-1:0] hash;
  } fin_t;

  function automatic logic [BYTE_W-1:0] fold_byte(input logic [BYTE_W-1:0] b,
                                                  input logic            en);
    logic [BYTE_W-1:0] r;
    r = b;
    if (en && (b >= UPPER_FIRST) && (b <= UPPER_LAST)) begin
      r = b + CASE_OFFSET;
    end
    return r;
  endfunction

  function automatic logic [HASH_W-1:0] mix_byte(input logic [HASH_W-1:0] h,
                                                 input logic [BYTE_W-1:0] b);
    logic [HASH_W-1:0] t;
    t = h + {{(HASH_W-BYTE_W){1'b0}}, b};
    t = t + (t << 10);
    t = t ^ (t >> 6);
    return t;
  endfunction

  function automatic logic [HASH_W-1:0] finish(input logic [HASH_W-1:0] h);
    logic [HASH_W-1:0] t;
    t = h + (h << 3);
    t = t ^ (t >> 11);
    t = t + (t << 15);
    return t;
  endfunction

endpackage

>>> rtl/oaat_if.sv
`timescale 1ns / 1ps

interface oaat_in_if;
  import oaat_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] char_byte;
  logic              has_byte;
  logic              last_byte;
  modport source (output valid, output char_byte, output has_byte, output last_byte,
                  input ready);
  modport sink   (input valid, input char_byte, input has_byte, input last_byte,
                  output ready);
endinterface

interface oaat_out_if;
  import oaat_pkg::*;
  logic              valid;
  logic              ready;
  logic [HASH_W-1:0] hash_value;
  modport source (output valid, output hash_value, input ready);
  modport sink   (input valid, input hash_value, output ready);
endinterface

interface oaat_cfg_if;
  logic valid;
  logic ready;
  logic fold_case;
  modport source (output valid, output fold_case, input ready);
  modport sink   (input valid, input fold_case, output ready);
endinterface

>>> rtl/oaat_mix.sv
`timescale 1ns / 1ps

module oaat_mix (
  input  logic            clk,
  input  logic            rst_n,
  oaat_in_if.sink         in_ch,
  input  logic            fold_case,
  output oaat_pkg::fin_t  fin_o,
  input  logic            fin_ready
);
  import oaat_pkg::*;

  logic              s1_v_r;
  logic [BYTE_W-1:0] s1_byte_r;
  logic              s1_has_r;
  logic              s1_last_r;
  logic [HASH_W-1:0] hash_r;
  logic [HASH_W-1:0] hash_nxt;
  logic [HASH_W-1:0] mixed;
  logic              s1_adv;

  assign mixed    = s1_has_r ? mix_byte(hash_r, s1_byte_r) : hash_r;
  // A last word can only leave once the finalizer has room for it.
  assign s1_adv   = s1_v_r && (!s1_last_r || fin_ready);
  assign in_ch.ready = !s1_v_r || s1_adv;
  assign hash_nxt = s1_last_r ? '0 : mixed;

  assign fin_o.valid = s1_v_r && s1_last_r;
  assign fin_o.hash  = mixed;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      hash_r <= '0;
    end else begin
      if (in_ch.ready) begin
        s1_v_r <= in_ch.valid;
      end
      if (s1_adv) begin
        hash_r <= hash_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_byte_r <= fold_byte(in_ch.char_byte, fold_case);
      s1_has_r  <= in_ch.has_byte;
      s1_last_r <= in_ch.last_byte;
    end
  end

endmodule

>>> rtl/oaat_final.sv
`timescale 1ns / 1ps

module oaat_final (
  input  logic            clk,
  input  logic            rst_n,
  input  oaat_pkg::fin_t  fin_i,
  output logic            fin_ready,
  oaat_out_if.source      out_ch
);
  import oaat_pkg::*;

  logic              fin_v_r;
  logic [HASH_W-1:0] fin_h_r;
  logic              out_v_r;
  logic [HASH_W-1:0] out_h_r;
  logic              out_ok;

  assign out_ok    = !out_v_r || out_ch.ready;
  assign fin_ready = !fin_v_r || out_ok;

  assign out_ch.valid      = out_v_r;
  assign out_ch.hash_value = out_h_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fin_v_r <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (fin_ready) begin
        fin_v_r <= fin_i.valid;
      end
      if (out_ok) begin
        out_v_r <= fin_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fin_ready && fin_i.valid) begin
      fin_h_r <= fin_i.hash;
    end
    if (out_ok && fin_v_r) begin
      out_h_r <= finish(fin_h_r);
    end
  end

endmodule

>>> rtl/case_folded_one_at_a_time_hash.sv
`timescale 1ns / 1ps
// One-at-a-time 32-bit string hash with optional ASCII case folding.
// in_ch carries one word per string byte: char_byte, has_byte and last_byte.
// A word with has_byte low mixes nothing in; on an empty string that word
// also carries last_byte, and the hash comes out as zero.
// out_ch carries one hash_value per string, for the word marked last_byte.
// cfg_ch writes fold_case and is always ready. The user must write it only
// while the block is idle; the block does not enforce this. With fold_case
// set, 'A' to 'Z' hash as 'a' to 'z'. Throughput is one word per cycle
// while no last word waits in the input stage for the finalizer. A byte
// is registered in the input stage and then mixed into the running-hash
// register, the loop that sets this rate. A result passes the input
// register, the finalizer input register and the result register.
// Reset clears the running hash and all stage valids, and sets fold_case.
// When out_ch stalls, the result register holds; the stages behind it keep
// taking words until a second and third last word back up behind it, and
// words that produce no result keep flowing as long as the input stage can
// hand its word on.
module case_folded_one_at_a_time_hash (
  input  logic       clk,
  input  logic       rst_n,
  oaat_in_if.sink    in_ch,
  oaat_out_if.source out_ch,
  oaat_cfg_if.sink   cfg_ch
);
  import oaat_pkg::*;

  logic fold_case_r;
  fin_t fin;
  logic fin_ready;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fold_case_r <= 1'b1;
    end else if (cfg_ch.valid) begin
      fold_case_r <= cfg_ch.fold_case;
    end
  end

  oaat_mix u_mix (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .fold_case (fold_case_r),
    .fin_o     (fin),
    .fin_ready (fin_ready)
  );

  oaat_final u_final (
    .clk       (clk),
    .rst_n     (rst_n),
    .fin_i     (fin),
    .fin_ready (fin_ready),
    .out_ch    (out_ch)
  );

endmodule

>>> test/case_folded_one_at_a_time_hash_test.sv
`timescale 1ns / 1ps

module case_folded_one_at_a_time_hash_test;
  import oaat_pkg::*;

  localparam int SETTLE_CYCLES = 8;
  localparam int LONG_HOLD     = 300;
  localparam int PHASE_WORDS   = 240;

  typedef struct packed {
    logic [BYTE_W-1:0] ch;
    logic              present;
    logic              ends;
  } text_word_t;

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_RHYTHM} rx_mode_t;

  logic clk;
  logic rst_n;

  oaat_in_if  in_ch ();
  oaat_out_if out_ch ();
  oaat_cfg_if cfg_ch ();

  case_folded_one_at_a_time_hash uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  text_word_t        pending_words[$];
  logic [HASH_W-1:0] hashes_due[$];
  int                words_counted;
  int                mismatches;
  logic              steady_send;
  int                hold_reqs;

  // Shadow state of the hash block.
  logic [HASH_W-1:0] running_sum;
  logic              fold_on;
  logic              word_taken;

  function automatic logic [BYTE_W-1:0] lower_if_upper(input logic [BYTE_W-1:0] b,
                                                       input logic            en);
    if (en && b >= UPPER_FIRST && b <= UPPER_LAST) begin
      return b + CASE_OFFSET;
    end
    return b;
  endfunction

  function automatic logic [HASH_W-1:0] stir_byte(input logic [HASH_W-1:0] acc,
                                                  input logic [BYTE_W-1:0] b);
    logic [HASH_W-1:0] t;
    t = acc + {{(HASH_W-BYTE_W){1'b0}}, b};
    t = t + (t << 10);
    t = t ^ (t >> 6);
    return t;
  endfunction

  function automatic logic [HASH_W-1:0] avalanche(input logic [HASH_W-1:0] acc);
    logic [HASH_W-1:0] t;
    t = acc + (acc << 3);
    t = t ^ (t >> 11);
    t = t + (t << 15);
    return t;
  endfunction

  // Letters and the bytes around them are favored so folding gets exercised.
  function automatic logic [BYTE_W-1:0] pick_byte();
    int r;
    logic [BYTE_W-1:0] edges[10];
    edges = '{8'h00, 8'hFF, 8'h40, 8'h41, 8'h5A, 8'h5B, 8'h60, 8'h7A, 8'hC1, 8'hDA};
    r = $urandom_range(0, 9);
    if (r < 4) return UPPER_FIRST + 8'($urandom_range(0, 25));
    if (r < 6) return UPPER_FIRST + CASE_OFFSET + 8'($urandom_range(0, 25));
    if (r < 7) return edges[$urandom_range(0, 9)];
    return 8'($urandom);
  endfunction

  function automatic int pick_len(input logic short_only);
    int r;
    r = $urandom_range(0, 19);
    if (short_only) return $urandom_range(0, 2);
    if (r == 0) return 0;
    if (r < 3) return $urandom_range(20, 40);
    return $urandom_range(1, 8);
  endfunction

  task automatic add_word(input logic [BYTE_W-1:0] ch, input logic present,
                          input logic ends);
    text_word_t w;
    w.ch      = ch;
    w.present = present;
    w.ends    = ends;
    pending_words.push_back(w);
    if (present || ends) words_counted++;
  endtask

  task automatic add_string(input int len);
    logic bare_end;
    bare_end = (len == 0) || ($urandom_range(0, 7) == 0);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 15) == 0) add_word(8'($urandom), 1'b0, 1'b0);
      add_word(pick_byte(), 1'b1, (i == len - 1) && !bare_end);
    end
    // A closing word without a byte finalizes what came before; char_byte is noise.
    if (bare_end) add_word(8'($urandom), 1'b0, 1'b1);
  endtask

  task automatic settle();
    while (pending_words.size() != 0 || in_ch.valid || hashes_due.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_fold(input logic v);
    @(negedge clk);
    cfg_ch.valid     <= 1'b1;
    cfg_ch.fold_case <= v;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("[case_folded_one_at_a_time_hash] ERROR");
    $finish;
  end

  // Sender: bursts of words separated by random gaps.
  int burst_left;
  int gap_left;

  always @(negedge clk) begin
    text_word_t w;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || word_taken) begin
      if (gap_left > 0) begin
        gap_left--;
        in_ch.valid <= 1'b0;
      end else if (pending_words.size() == 0) begin
        in_ch.valid <= 1'b0;
      end else begin
        w = pending_words.pop_front();
        in_ch.char_byte <= w.ch;
        in_ch.has_byte  <= w.present;
        in_ch.last_byte <= w.ends;
        in_ch.valid     <= 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 40);
          gap_left = (steady_send || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end
      end
    end
  end

  // Receiver: changing stall patterns, plus a long hold-off on request.
  rx_mode_t rx_mode;
  int       mode_left;
  int       rhythm;
  int       hold_left;
  int       holds_done;

  always @(negedge clk) begin
    if (hold_reqs != holds_done) begin
      holds_done++;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        rx_mode   = rx_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(16, 160);
      end else begin
        mode_left--;
      end
      rhythm++;
      case (rx_mode)
        RX_OPEN:   out_ch.ready <= 1'b1;
        RX_COIN:   out_ch.ready <= 1'($urandom_range(0, 1));
        RX_SPARSE: out_ch.ready <= ($urandom_range(0, 5) == 0);
        default:   out_ch.ready <= (rhythm % 3 == 0);
      endcase
    end
  end

  // Monitor: checks each hash and predicts the next ones from accepted words.
  always @(posedge clk) begin
    logic [HASH_W-1:0] want;
    word_taken <= in_ch.valid && in_ch.ready;
    if (!rst_n) begin
      running_sum = '0;
      fold_on     = 1'b1;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) fold_on = cfg_ch.fold_case;
      if (out_ch.valid && out_ch.ready) begin
        if (hashes_due.size() == 0) begin
          $error("hash_value: expected none, got %h", out_ch.hash_value);
          mismatches++;
        end else begin
          want = hashes_due.pop_front();
          if (out_ch.hash_value !== want) begin
            $error("hash_value: expected %h, got %h", want, out_ch.hash_value);
            mismatches++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        if (in_ch.has_byte) begin
          running_sum = stir_byte(running_sum, lower_if_upper(in_ch.char_byte, fold_on));
        end
        if (in_ch.last_byte) begin
          hashes_due.push_back(avalanche(running_sum));
          running_sum = '0;
        end
      end
    end
  end

  initial begin
    int guard;
    int target;
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.char_byte  = '0;
    in_ch.has_byte   = 1'b0;
    in_ch.last_byte  = 1'b0;
    out_ch.ready     = 1'b0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.fold_case = 1'b0;
    steady_send      = 1'b0;
    hold_reqs        = 0;
    holds_done       = 0;
    burst_left       = 0;
    gap_left         = 0;
    mode_left        = 0;
    rhythm           = 0;
    hold_left        = 0;
    mismatches       = 0;
    words_counted    = 0;
    word_taken       = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed words with folding on from reset.
    add_word(8'hFF, 1'b0, 1'b1);              // empty string
    add_word(8'h00, 1'b1, 1'b1);
    add_word(8'hFF, 1'b1, 1'b1);
    add_word(8'h41, 1'b1, 1'b1);
    add_word(8'h5A, 1'b1, 1'b1);
    add_word(8'h40, 1'b1, 1'b1);
    add_word(8'h5B, 1'b1, 1'b1);
    add_word(8'h61, 1'b1, 1'b1);
    add_word(8'h7A, 1'b1, 1'b1);
    add_word(8'hC1, 1'b1, 1'b1);
    add_word(8'h41, 1'b1, 1'b0);
    add_word(8'h00, 1'b0, 1'b0);              // word without a byte in mid-string
    add_word(8'h62, 1'b1, 1'b0);
    add_word(8'h5A, 1'b1, 1'b0);
    add_word(8'h51, 1'b0, 1'b1);              // string closed by a word without a byte
    add_word(8'h00, 1'b0, 1'b1);
    settle();

    write_fold(1'b0);
    add_word(8'h41, 1'b1, 1'b1);
    add_word(8'h5A, 1'b1, 1'b1);
    add_word(8'h41, 1'b1, 1'b0);
    add_word(8'h5A, 1'b1, 1'b0);
    add_word(8'h61, 1'b1, 1'b0);
    add_word(8'h7A, 1'b1, 1'b1);
    add_word(8'hFF, 1'b0, 1'b1);
    settle();

    for (int p = 0; p < 6; p++) begin
      write_fold((p % 2 == 0) ? 1'b1 : 1'b0);
      steady_send = (p == 2 || p == 3);
      target = words_counted + PHASE_WORDS;
      while (words_counted < target) add_string(pick_len(p == 3));
      // Short strings back up behind a receiver that is held off for a while.
      if (p == 3) hold_reqs++;
      settle();
    end

    guard = 0;
    while (hashes_due.size() != 0 && guard < 50000) begin
      @(posedge clk);
      guard++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (hashes_due.size() != 0) begin
      $error("hash_value: %0d expected results never arrived", hashes_due.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("[case_folded_one_at_a_time_hash] OK");
    end else begin
      $display("[case_folded_one_at_a_time_hash] ERROR");
    end
    $finish;
  end

endmodule
